FILE: src/mvne_pkg.sv
// shared types and constants of the mesh vertex normal engine
package mvne_pkg;

    // vertex table geometry
    localparam int VIDX_W       = 10;
    localparam int VERTEX_COUNT = 1 << VIDX_W;

    // field and arithmetic widths
    localparam int COORD_W   = 32;
    localparam int ACC_W     = 24;
    localparam int NORM_W    = 16;
    localparam int NORM_FRAC = 14;
    localparam int FIT_BITS  = 30;
    localparam int QUOT_W    = NORM_FRAC + 1;
    localparam int LEN_W     = 31;
    localparam int WIDE_W    = 64;

    localparam logic [QUOT_W-1:0] NORM_ONE = QUOT_W'(1) << NORM_FRAC;

    // root and divide unit step counts
    localparam int SQRT_STEPS = WIDE_W / 2;
    localparam int DIV_STEPS  = QUOT_W;

    // request codes
    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_TRI   = 2'd1,
        REQ_READ  = 2'd2,
        REQ_CLEAR = 2'd3
    } req_kind_t;

    // root and divide unit control
    typedef enum logic {
        RD_SQRT = 1'b0,
        RD_DIV  = 1'b1
    } rd_op_t;

    typedef struct packed {
        logic   start;
        rd_op_t op;
    } rd_cmd_t;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] value;
    } rd_stat_t;

endpackage

FILE: src/mvne_req_if.sv
// request channel interface
interface mvne_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          req_type;
    logic [mvne_pkg::VIDX_W-1:0]         vertex_index;
    logic signed [mvne_pkg::COORD_W-1:0] pos_x;
    logic signed [mvne_pkg::COORD_W-1:0] pos_y;
    logic signed [mvne_pkg::COORD_W-1:0] pos_z;
    logic [mvne_pkg::VIDX_W-1:0]         corner_a;
    logic [mvne_pkg::VIDX_W-1:0]         corner_b;
    logic [mvne_pkg::VIDX_W-1:0]         corner_c;

    modport source (output valid, req_type, vertex_index, pos_x, pos_y, pos_z,
                    corner_a, corner_b, corner_c, input ready);
    modport sink   (input valid, req_type, vertex_index, pos_x, pos_y, pos_z,
                    corner_a, corner_b, corner_c, output ready);
endinterface

FILE: src/mvne_rsp_if.sv
// result channel interface
interface mvne_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         result_kind;
    logic signed [mvne_pkg::NORM_W-1:0] normal_x;
    logic signed [mvne_pkg::NORM_W-1:0] normal_y;
    logic signed [mvne_pkg::NORM_W-1:0] normal_z;
    logic                               zero_length;

    modport source (output valid, result_kind, normal_x, normal_y, normal_z,
                    zero_length, input ready);
    modport sink   (input valid, result_kind, normal_x, normal_y, normal_z,
                    zero_length, output ready);
endinterface

FILE: src/mvne_mul.sv
// registered 32x32 signed multiplier shared by cross product and squares
module mvne_mul (
    input  logic                                clk,
    input  logic signed [31:0]                  a,
    input  logic signed [31:0]                  b,
    output logic signed [mvne_pkg::WIDE_W-1:0]  p
);
    import mvne_pkg::*;

    logic signed [WIDE_W-1:0] p_reg;

    // one product per cycle
    always_ff @(posedge clk)
    begin
        p_reg <= WIDE_W'(a) * WIDE_W'(b);
    end

    assign p = p_reg;

endmodule

FILE: src/mvne_root_div.sv
// iterative integer square root and restoring divide on one compare-subtract
module mvne_root_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mvne_pkg::rd_cmd_t                 cmd,
    input  logic [mvne_pkg::WIDE_W-1:0]       opa,
    input  logic [mvne_pkg::LEN_W-1:0]        opb,
    output mvne_pkg::rd_stat_t                stat
);
    import mvne_pkg::*;

    localparam logic [WIDE_W-1:0] SQRT_TOP = WIDE_W'(1) << (WIDE_W - 2);

    logic              busy_reg;
    logic              done_reg;
    rd_op_t            op_reg;
    logic [WIDE_W-1:0] x_reg;
    logic [WIDE_W-1:0] r_reg;
    logic [WIDE_W-1:0] step_reg;
    logic [4:0]        k_reg;

    logic [WIDE_W-1:0] sub;
    logic              ge;

    // shared operand: root candidate or shifted divisor
    always_comb
    begin
        sub = (op_reg == RD_SQRT) ? r_reg + step_reg : step_reg;
        ge  = x_reg >= sub;
    end

    // one result bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= cmd.op;
                x_reg    <= opa;
                r_reg    <= '0;
                if (cmd.op == RD_SQRT)
                begin
                    step_reg <= SQRT_TOP;
                    k_reg    <= 5'(SQRT_STEPS - 1);
                end
                else
                begin
                    step_reg <= WIDE_W'(opb) << (DIV_STEPS - 1);
                    k_reg    <= 5'(DIV_STEPS - 1);
                end
            end
            else if (busy_reg)
            begin
                if (ge)
                begin
                    x_reg <= x_reg - sub;
                end
                if (op_reg == RD_SQRT)
                begin
                    r_reg    <= ge ? (r_reg >> 1) + step_reg : r_reg >> 1;
                    step_reg <= step_reg >> 2;
                end
                else
                begin
                    r_reg    <= {r_reg[WIDE_W-2:0], ge};
                    step_reg <= step_reg >> 1;
                end
                k_reg <= k_reg - 5'd1;
                if (k_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.done  = done_reg;
    assign stat.value = r_reg[LEN_W-1:0];

endmodule

FILE: src/mesh_vertex_normal_engine.sv
// Vertex normal engine: positions are loaded into a table, each triangle adds its unit face
// normal (Q1.14) to the saturating 24-bit sums of its three corners, and a read returns the
// normalized sum of one vertex. One item is worked at a time on a shared 32x32 multiplier and
// a shared bit-per-cycle root/divide unit. A clear zeroes one accumulator row per cycle. A read
// or a triangle runs the square root, three divides and the one-bit-a-cycle range fitting
// shifts; a degenerate face or a zero sum skips the root and the divides. The edge fit takes
// up to 2 shifts and the cross product fit up to 31. A result that waits on the result side
// holds the next result back. After reset the block sweeps all 1024 accumulator rows to zero
// and takes no request while it does. The result register lets the next request start while
// a result waits.
module mesh_vertex_normal_engine (
    input  logic       clk,
    input  logic       rst_n,
    mvne_req_if.sink   req,
    mvne_rsp_if.source rsp
);
    import mvne_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_T_RA, ST_T_RB, ST_T_RC, ST_T_E2, ST_T_FIT, ST_T_MUL,
        ST_R_RD, ST_R_LD, ST_N_ZERO, ST_N_FIT, ST_N_SQ, ST_N_SQRT, ST_N_SQRT_W,
        ST_N_DIV, ST_N_DIV_W, ST_A_RD, ST_A_WR, ST_DONE
    } state_t;

    localparam int POS_W = 3 * COORD_W;
    localparam int SUM_W = 3 * ACC_W;
    localparam logic signed [ACC_W:0] ACC_MAX = (ACC_W+1)'((1 << (ACC_W - 1)) - 1);
    localparam logic signed [ACC_W:0] ACC_MIN = -(ACC_W+1)'(1 << (ACC_W - 1));

    // memories
    logic [POS_W-1:0] pos_mem [VERTEX_COUNT];
    logic [SUM_W-1:0] sum_mem [VERTEX_COUNT];
    logic [POS_W-1:0] pos_rd_reg;
    logic [SUM_W-1:0] sum_rd_reg;

    // control
    state_t              state_reg;
    logic [2:0]          cnt_reg;
    logic [VIDX_W-1:0]   clr_cnt_reg;
    logic                clr_req_reg;
    logic                rsp_valid_reg;

    // request fields
    req_kind_t           kind_reg;
    logic [VIDX_W-1:0]   vidx_reg;
    logic [VIDX_W-1:0]   corner_reg [3];

    // datapath
    logic [POS_W-1:0]         pa_reg;
    logic [COORD_W-1:0]       e_mag_reg [6];
    logic                     e_sg_reg  [6];
    logic signed [WIDE_W-1:0] acc_reg;
    logic signed [WIDE_W-1:0] c_reg [3];
    logic [WIDE_W-2:0]        m_reg [3];
    logic                     sg_reg [3];
    logic [WIDE_W-1:0]        sum_reg;
    logic [LEN_W-1:0]         len_reg;
    logic [QUOT_W-1:0]        q_reg [3];
    logic                     zero_reg;

    // result register
    logic [1:0]               out_kind_reg;
    logic signed [NORM_W-1:0] out_n_reg [3];
    logic                     out_zero_reg;

    // combinational
    logic [VIDX_W-1:0]        pos_addr;
    logic [VIDX_W-1:0]        sum_addr;
    logic                     sum_we;
    logic [SUM_W-1:0]         sum_wdata;
    logic [COORD_W-1:0]       d_mag [3];
    logic                     d_sg  [3];
    logic [COORD_W-1:0]       e_or;
    logic [WIDE_W-2:0]        m_or;
    logic signed [31:0]       mul_a;
    logic signed [31:0]       mul_b;
    logic signed [WIDE_W-1:0] mul_p;
    logic [2:0]               prod_idx;
    logic [1:0]               cidx;
    logic signed [NORM_W-1:0] fn [3];
    logic                     c_zero;
    rd_cmd_t                  rd_cmd;
    logic [WIDE_W-1:0]        rd_opa;
    rd_stat_t                 rd_stat;
    logic                     req_fire;

    function automatic logic signed [31:0] edge_val(input logic sg, input logic [COORD_W-1:0] mg);
        logic signed [31:0] v;
        v = $signed({1'b0, mg[30:0]});
        return sg ? -v : v;
    endfunction

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign cidx      = cnt_reg[1:0];
    assign prod_idx  = cnt_reg - 3'd1;

    // edge from the first corner, as sign and magnitude
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            logic [COORD_W:0] d;
            d = {pos_rd_reg[POS_W-1-COORD_W*i], pos_rd_reg[POS_W-1-COORD_W*i -: COORD_W]}
              - {pa_reg[POS_W-1-COORD_W*i], pa_reg[POS_W-1-COORD_W*i -: COORD_W]};
            d_sg[i]  = d[COORD_W];
            d_mag[i] = d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
        end
    end

    // range fitting and face normal terms
    always_comb
    begin
        e_or = '0;
        for (int i = 0; i < 6; i++)
        begin
            e_or = e_or | e_mag_reg[i];
        end
        m_or   = m_reg[0] | m_reg[1] | m_reg[2];
        c_zero = (c_reg[0] == '0) && (c_reg[1] == '0) && (c_reg[2] == '0);
        for (int i = 0; i < 3; i++)
        begin
            fn[i] = sg_reg[i] ? -NORM_W'(q_reg[i]) : NORM_W'(q_reg[i]);
        end
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_T_MUL)
        begin
            case (cnt_reg)
                3'd0:
                begin
                    mul_a = edge_val(e_sg_reg[1], e_mag_reg[1]);
                    mul_b = edge_val(e_sg_reg[5], e_mag_reg[5]);
                end
                3'd1:
                begin
                    mul_a = edge_val(e_sg_reg[2], e_mag_reg[2]);
                    mul_b = edge_val(e_sg_reg[4], e_mag_reg[4]);
                end
                3'd2:
                begin
                    mul_a = edge_val(e_sg_reg[2], e_mag_reg[2]);
                    mul_b = edge_val(e_sg_reg[3], e_mag_reg[3]);
                end
                3'd3:
                begin
                    mul_a = edge_val(e_sg_reg[0], e_mag_reg[0]);
                    mul_b = edge_val(e_sg_reg[5], e_mag_reg[5]);
                end
                3'd4:
                begin
                    mul_a = edge_val(e_sg_reg[0], e_mag_reg[0]);
                    mul_b = edge_val(e_sg_reg[4], e_mag_reg[4]);
                end
                3'd5:
                begin
                    mul_a = edge_val(e_sg_reg[1], e_mag_reg[1]);
                    mul_b = edge_val(e_sg_reg[3], e_mag_reg[3]);
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
        else if (state_reg == ST_N_SQ && cnt_reg < 3'd3)
        begin
            mul_a = $signed(m_reg[cidx][31:0]);
            mul_b = $signed(m_reg[cidx][31:0]);
        end
    end

    // root and divide unit commands
    always_comb
    begin
        rd_cmd.start = (state_reg == ST_N_SQRT) || (state_reg == ST_N_DIV);
        rd_cmd.op    = (state_reg == ST_N_DIV) ? RD_DIV : RD_SQRT;
        if (state_reg == ST_N_DIV)
        begin
            rd_opa = WIDE_W'({m_reg[cidx][FIT_BITS-1:0], NORM_FRAC'(0)})
                   + WIDE_W'(len_reg >> 1);
        end
        else
        begin
            rd_opa = sum_reg;
        end
    end

    // memory addresses and accumulator update
    always_comb
    begin
        unique case (state_reg)
            ST_T_RB: pos_addr = corner_reg[1];
            ST_T_RC: pos_addr = corner_reg[2];
            default: pos_addr = corner_reg[0];
        endcase
        unique case (state_reg)
            ST_CLEAR:         sum_addr = clr_cnt_reg;
            ST_A_RD, ST_A_WR: sum_addr = corner_reg[cidx];
            default:          sum_addr = vidx_reg;
        endcase
        sum_we    = (state_reg == ST_CLEAR) || (state_reg == ST_A_WR);
        sum_wdata = '0;
        if (state_reg == ST_A_WR)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic signed [ACC_W:0] s;
                s = $signed({sum_rd_reg[SUM_W-1-ACC_W*i], sum_rd_reg[SUM_W-1-ACC_W*i -: ACC_W]})
                  + (ACC_W+1)'(fn[i]);
                if (s > ACC_MAX)
                begin
                    s = ACC_MAX;
                end
                else if (s < ACC_MIN)
                begin
                    s = ACC_MIN;
                end
                sum_wdata[SUM_W-1-ACC_W*i -: ACC_W] = s[ACC_W-1:0];
            end
        end
    end

    // position table
    always_ff @(posedge clk)
    begin
        if (req_fire && req_kind_t'(req.req_type) == REQ_LOAD)
        begin
            pos_mem[req.vertex_index] <= {req.pos_x, req.pos_y, req.pos_z};
        end
        pos_rd_reg <= pos_mem[pos_addr];
    end

    // accumulator table
    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_addr] <= sum_wdata;
        end
        sum_rd_reg <= sum_mem[sum_addr];
    end

    mvne_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    mvne_root_div u_root_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (rd_cmd),
        .opa   (rd_opa),
        .opb   (len_reg),
        .stat  (rd_stat)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            clr_cnt_reg   <= '0;
            clr_req_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready && state_reg != ST_DONE)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + VIDX_W'(1);
                    if (clr_cnt_reg == VIDX_W'(VERTEX_COUNT - 1))
                    begin
                        state_reg <= clr_req_reg ? ST_DONE : ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (req_fire)
                    begin
                        kind_reg      <= req_kind_t'(req.req_type);
                        vidx_reg      <= req.vertex_index;
                        corner_reg[0] <= req.corner_a;
                        corner_reg[1] <= req.corner_b;
                        corner_reg[2] <= req.corner_c;
                        zero_reg      <= 1'b0;
                        unique case (req_kind_t'(req.req_type))
                            REQ_LOAD:  state_reg <= ST_DONE;
                            REQ_TRI:   state_reg <= ST_T_RA;
                            REQ_READ:  state_reg <= ST_R_RD;
                            REQ_CLEAR:
                            begin
                                clr_cnt_reg <= '0;
                                clr_req_reg <= 1'b1;
                                state_reg   <= ST_CLEAR;
                            end
                            default:   state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_T_RA:
                begin
                    state_reg <= ST_T_RB;
                end
                ST_T_RB:
                begin
                    pa_reg    <= pos_rd_reg;
                    state_reg <= ST_T_RC;
                end
                ST_T_RC:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        e_mag_reg[i] <= d_mag[i];
                        e_sg_reg[i]  <= d_sg[i];
                    end
                    state_reg <= ST_T_E2;
                end
                ST_T_E2:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        e_mag_reg[3+i] <= d_mag[i];
                        e_sg_reg[3+i]  <= d_sg[i];
                    end
                    state_reg <= ST_T_FIT;
                end
                ST_T_FIT:
                begin
                    // halve all edges until each is below the fit limit
                    if (e_or[COORD_W-1:FIT_BITS] != '0)
                    begin
                        for (int i = 0; i < 6; i++)
                        begin
                            e_mag_reg[i] <= e_mag_reg[i] >> 1;
                        end
                    end
                    else
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_T_MUL;
                    end
                end
                ST_T_MUL:
                begin
                    // pairs of products give the cross components
                    if (cnt_reg != 3'd0)
                    begin
                        if (!prod_idx[0])
                        begin
                            acc_reg <= mul_p;
                        end
                        else
                        begin
                            c_reg[prod_idx[2:1]] <= acc_reg - mul_p;
                        end
                    end
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd6)
                    begin
                        state_reg <= ST_N_ZERO;
                    end
                end
                ST_R_RD:
                begin
                    state_reg <= ST_R_LD;
                end
                ST_R_LD:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        c_reg[i] <= WIDE_W'($signed(sum_rd_reg[SUM_W-1-ACC_W*i -: ACC_W]));
                    end
                    state_reg <= ST_N_ZERO;
                end
                ST_N_ZERO:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        sg_reg[i] <= c_reg[i][WIDE_W-1];
                        m_reg[i]  <= c_reg[i][WIDE_W-1] ? (WIDE_W-1)'(-c_reg[i])
                                                         : c_reg[i][WIDE_W-2:0];
                        q_reg[i]  <= '0;
                    end
                    if (c_zero)
                    begin
                        zero_reg  <= 1'b1;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_N_FIT;
                    end
                end
                ST_N_FIT:
                begin
                    if (m_or[WIDE_W-2:FIT_BITS] != '0)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            m_reg[i] <= m_reg[i] >> 1;
                        end
                    end
                    else
                    begin
                        sum_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_N_SQ;
                    end
                end
                ST_N_SQ:
                begin
                    // sum of squares, one product a cycle
                    if (cnt_reg != 3'd0)
                    begin
                        sum_reg <= sum_reg + WIDE_W'(mul_p);
                    end
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd3)
                    begin
                        state_reg <= ST_N_SQRT;
                    end
                end
                ST_N_SQRT:
                begin
                    state_reg <= ST_N_SQRT_W;
                end
                ST_N_SQRT_W:
                begin
                    if (rd_stat.done)
                    begin
                        len_reg   <= rd_stat.value;
                        cnt_reg   <= '0;
                        state_reg <= ST_N_DIV;
                    end
                end
                ST_N_DIV:
                begin
                    state_reg <= ST_N_DIV_W;
                end
                ST_N_DIV_W:
                begin
                    if (rd_stat.done)
                    begin
                        q_reg[cidx] <= rd_stat.value[QUOT_W-1:0];
                        if (cnt_reg == 3'd2)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= (kind_reg == REQ_TRI) ? ST_A_RD : ST_DONE;
                        end
                        else
                        begin
                            cnt_reg   <= cnt_reg + 3'd1;
                            state_reg <= ST_N_DIV;
                        end
                    end
                end
                ST_A_RD:
                begin
                    state_reg <= ST_A_WR;
                end
                ST_A_WR:
                begin
                    if (cnt_reg == 3'd2)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + 3'd1;
                        state_reg <= ST_A_RD;
                    end
                end
                ST_DONE:
                begin
                    // hand the result over once the result register is free
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg <= 1'b1;
                        out_kind_reg  <= kind_reg;
                        out_zero_reg  <= zero_reg;
                        for (int i = 0; i < 3; i++)
                        begin
                            out_n_reg[i] <= (kind_reg == REQ_READ && !zero_reg) ? fn[i] : '0;
                        end
                        clr_req_reg <= 1'b0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.result_kind = out_kind_reg;
    assign rsp.normal_x    = out_n_reg[0];
    assign rsp.normal_y    = out_n_reg[1];
    assign rsp.normal_z    = out_n_reg[2];
    assign rsp.zero_length = out_zero_reg;

    // a quotient never exceeds unit length
    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_N_DIV_W && rd_stat.done) |-> rd_stat.value <= LEN_W'(NORM_ONE))
        else $error("normalized component above unit length");

    // a nonzero vector has a nonzero length
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_N_SQRT_W && rd_stat.done) |-> rd_stat.value != '0)
        else $error("zero length for nonzero vector");

    // the square root starts only on fitted magnitudes
    a_fit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_N_SQRT) |-> m_or[WIDE_W-2:FIT_BITS] == '0)
        else $error("magnitudes not fitted before square root");

    // only read results carry a normal
    a_normal_only_read: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.result_kind != 2'(REQ_READ)) |->
        (rsp.normal_x == '0 && rsp.normal_y == '0 && rsp.normal_z == '0))
        else $error("normal on a non-read result");

endmodule
